### rtl/core/trtr_pkg.sv
// Shared types and constants of the tilt-rotor transition ramp.
`default_nettype none

package trtr_pkg;

    // Channel widths that do not vary with the parameters
    localparam int IN_DATA_BITS   = 8;
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 16;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_RAMP1_TICKS = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RAMP2_TICKS = 8'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MC_SERVO_A  = 8'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MC_SERVO_B  = 8'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MID_SERVO_A = 8'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MID_SERVO_B = 8'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FW_SERVO_A  = 8'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FW_SERVO_B  = 8'd7;

    // Reset values of the configuration registers
    localparam int RST_RAMP1_TICKS = 600;
    localparam int RST_RAMP2_TICKS = 400;
    localparam int RST_MC_SERVO_A  = 2000;
    localparam int RST_MC_SERVO_B  = 1000;
    localparam int RST_MID_SERVO_A = 1500;
    localparam int RST_MID_SERVO_B = 1500;
    localparam int RST_FW_SERVO_A  = 1000;
    localparam int RST_FW_SERVO_B  = 2000;

    // Transition phase codes
    typedef logic [1:0] phase_t;
    localparam phase_t PH_MC    = 2'd0;
    localparam phase_t PH_RAMP1 = 2'd1;
    localparam phase_t PH_RAMP2 = 2'd2;
    localparam phase_t PH_FW    = 2'd3;

    // Airframe mode codes
    localparam logic AIR_MC = 1'b0;
    localparam logic AIR_FW = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_EMIT = 3'b100
    } seq_state_t;

    // Interpolation lane states
    typedef enum logic [3:0] {
        L_IDLE = 4'b0001,
        L_MUL  = 4'b0010,
        L_DIV  = 4'b0100,
        L_DONE = 4'b1000
    } lane_state_t;

endpackage

`default_nettype wire

### rtl/core/trtr_cfg.sv
// Configuration register file of the tilt-rotor transition ramp.
`default_nettype none

module trtr_cfg #(
    parameter int PULSE_BITS = 12,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                wr_en,
    input  wire logic [trtr_pkg::CFG_INDEX_BITS-1:0] wr_index,
    input  wire logic [trtr_pkg::CFG_DATA_BITS-1:0]  wr_data,
    output logic      [COUNT_BITS-1:0]               ramp1_ticks,
    output logic      [COUNT_BITS-1:0]               ramp2_ticks,
    output logic      [PULSE_BITS-1:0]               mc_servo_a,
    output logic      [PULSE_BITS-1:0]               mc_servo_b,
    output logic      [PULSE_BITS-1:0]               mid_servo_a,
    output logic      [PULSE_BITS-1:0]               mid_servo_b,
    output logic      [PULSE_BITS-1:0]               fw_servo_a,
    output logic      [PULSE_BITS-1:0]               fw_servo_b
);
    import trtr_pkg::*;

    logic [COUNT_BITS-1:0] ramp1_ticks_reg;
    logic [COUNT_BITS-1:0] ramp2_ticks_reg;
    logic [PULSE_BITS-1:0] mc_servo_a_reg;
    logic [PULSE_BITS-1:0] mc_servo_b_reg;
    logic [PULSE_BITS-1:0] mid_servo_a_reg;
    logic [PULSE_BITS-1:0] mid_servo_b_reg;
    logic [PULSE_BITS-1:0] fw_servo_a_reg;
    logic [PULSE_BITS-1:0] fw_servo_b_reg;
    logic [COUNT_BITS-1:0] count_val;
    logic [PULSE_BITS-1:0] pulse_val;

    // Mask the written word to the register widths
    assign count_val = wr_data[COUNT_BITS-1:0];
    assign pulse_val = wr_data[PULSE_BITS-1:0];

    // Write the addressed register; drop writes beyond the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp1_ticks_reg <= COUNT_BITS'(RST_RAMP1_TICKS);
            ramp2_ticks_reg <= COUNT_BITS'(RST_RAMP2_TICKS);
            mc_servo_a_reg  <= PULSE_BITS'(RST_MC_SERVO_A);
            mc_servo_b_reg  <= PULSE_BITS'(RST_MC_SERVO_B);
            mid_servo_a_reg <= PULSE_BITS'(RST_MID_SERVO_A);
            mid_servo_b_reg <= PULSE_BITS'(RST_MID_SERVO_B);
            fw_servo_a_reg  <= PULSE_BITS'(RST_FW_SERVO_A);
            fw_servo_b_reg  <= PULSE_BITS'(RST_FW_SERVO_B);
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_RAMP1_TICKS: ramp1_ticks_reg <= count_val;
                REG_RAMP2_TICKS: ramp2_ticks_reg <= count_val;
                REG_MC_SERVO_A:  mc_servo_a_reg  <= pulse_val;
                REG_MC_SERVO_B:  mc_servo_b_reg  <= pulse_val;
                REG_MID_SERVO_A: mid_servo_a_reg <= pulse_val;
                REG_MID_SERVO_B: mid_servo_b_reg <= pulse_val;
                REG_FW_SERVO_A:  fw_servo_a_reg  <= pulse_val;
                REG_FW_SERVO_B:  fw_servo_b_reg  <= pulse_val;
                default:         ;
            endcase
        end
    end

    assign ramp1_ticks = ramp1_ticks_reg;
    assign ramp2_ticks = ramp2_ticks_reg;
    assign mc_servo_a  = mc_servo_a_reg;
    assign mc_servo_b  = mc_servo_b_reg;
    assign mid_servo_a = mid_servo_a_reg;
    assign mid_servo_b = mid_servo_b_reg;
    assign fw_servo_a  = fw_servo_a_reg;
    assign fw_servo_b  = fw_servo_b_reg;

endmodule

`default_nettype wire

### rtl/core/trtr_lerp.sv
// Bit-serial interpolation lane: floor(a + (b - a) * k / n), one bit per cycle.
`default_nettype none

module trtr_lerp #(
    parameter int PULSE_BITS = 12,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [PULSE_BITS-1:0] a,
    input  wire logic [PULSE_BITS-1:0] b,
    input  wire logic [COUNT_BITS-1:0] k,
    input  wire logic [COUNT_BITS-1:0] n,
    output logic                       done,
    output logic      [PULSE_BITS-1:0] y
);
    import trtr_pkg::*;

    localparam int PROD_BITS = PULSE_BITS + COUNT_BITS;
    localparam int MAX_STEPS = (COUNT_BITS > PULSE_BITS) ? COUNT_BITS : PULSE_BITS;
    localparam int STEP_BITS = $clog2(MAX_STEPS);

    lane_state_t           state_reg, state_next;
    logic [STEP_BITS-1:0]  step_reg, step_next;
    logic [PULSE_BITS-1:0] a_reg;
    logic                  neg_reg;
    logic [PULSE_BITS-1:0] mag_reg;
    logic [COUNT_BITS-1:0] k_reg;
    logic [COUNT_BITS-1:0] n_reg;
    logic [PROD_BITS-1:0]  prod_reg;
    logic [PROD_BITS-1:0]  prod_mul;
    logic [PROD_BITS-1:0]  prod_div;
    logic [COUNT_BITS:0]   trial;
    logic [COUNT_BITS:0]   diff;
    logic                  q_bit;
    logic [PULSE_BITS-1:0] quo;
    logic                  rem_nz;

    // Multiply step, high bit of k first: shift and conditionally add |b - a|
    assign prod_mul = {prod_reg[PROD_BITS-2:0], 1'b0}
                    + (k_reg[COUNT_BITS-1] ? PROD_BITS'(mag_reg) : '0);

    // Restoring divide step: remainder in the upper bits, quotient fills the lower
    assign trial    = prod_reg[PROD_BITS-1:PULSE_BITS-1];
    assign diff     = trial - {1'b0, n_reg};
    assign q_bit    = (trial >= {1'b0, n_reg});
    assign prod_div = {(q_bit ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0]),
                       prod_reg[PULSE_BITS-2:0], q_bit};

    // Floor the quotient toward minus infinity on a falling ramp
    assign quo    = prod_reg[PULSE_BITS-1:0];
    assign rem_nz = |prod_reg[PROD_BITS-1:PULSE_BITS];
    assign y      = neg_reg ? (a_reg - quo - PULSE_BITS'(rem_nz)) : (a_reg + quo);
    assign done   = (state_reg == L_DONE);

    // Advance through multiply and divide passes
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            L_IDLE:
            begin
                if (start)
                begin
                    state_next = L_MUL;
                    step_next  = STEP_BITS'(COUNT_BITS - 1);
                end
            end
            L_MUL:
            begin
                if (step_reg == '0)
                begin
                    state_next = L_DIV;
                    step_next  = STEP_BITS'(PULSE_BITS - 1);
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            L_DIV:
            begin
                if (step_reg == '0)
                begin
                    state_next = L_DONE;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            L_DONE:  state_next = L_IDLE;
            default: state_next = L_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Load operands on start, then shift the datapath one bit a cycle
    always_ff @(posedge clk)
    begin
        if (state_reg == L_IDLE && start)
        begin
            a_reg    <= a;
            neg_reg  <= (b < a);
            mag_reg  <= (b < a) ? (a - b) : (b - a);
            k_reg    <= k;
            n_reg    <= n;
            prod_reg <= '0;
        end
        else if (state_reg == L_MUL)
        begin
            prod_reg <= prod_mul;
            k_reg    <= {k_reg[COUNT_BITS-2:0], 1'b0};
        end
        else if (state_reg == L_DIV)
        begin
            prod_reg <= prod_div;
        end
    end

endmodule

`default_nettype wire

### rtl/core/tilt_rotor_transition_ramp.sv
// Top level of the tilt-rotor transition ramp: sequencer, output register.
//
// Usage: each item on the s_axis channel is one control tick carrying the
// multicopter and fixed-wing requests. For every tick the block returns one
// item on the m_axis channel with both servo pulses, the airframe mode and
// the transition phase, taken after that tick's update. Ramp lengths and
// servo end points are for the user to write through the cfg channel while
// the block is idle; the block does not enforce it. cfg_ready is always high.
// A ramp tick runs both servo interpolations in two bit-serial lanes, with a
// multiply pass over the bits of k and then a divide pass, before the result
// is held and passes through S_EMIT into the output register. A tick that
// only holds or changes phase goes from S_IDLE through S_EMIT into the
// output register. Handshake: one tick at a time; the next tick is taken
// once the previous result sits in the output register.
// Reset puts the block in multicopter phase with both counts and both servo
// holds at zero and the configuration at its defaults. When the receiver
// stalls, the result waits in the output register, one more tick may be
// worked on, and then s_axis_tready stays low until the register drains.
`default_nettype none

module tilt_rotor_transition_ramp #(
    parameter int PULSE_BITS = 12,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    // tdata: [0] req_multicopter, [1] req_fixed_wing, rest zero
    input  wire logic                                     s_axis_tvalid,
    output logic                                          s_axis_tready,
    input  wire logic [trtr_pkg::IN_DATA_BITS-1:0]        s_axis_tdata,
    // tdata: servo_a_pulse, servo_b_pulse, fixed_wing_mode, tilt_phase, zeros
    output logic                                          m_axis_tvalid,
    input  wire logic                                     m_axis_tready,
    output logic      [((2*PULSE_BITS+3+7)/8)*8-1:0]      m_axis_tdata,
    input  wire logic                                     cfg_valid,
    output logic                                          cfg_ready,
    input  wire logic [trtr_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
    input  wire logic [trtr_pkg::CFG_DATA_BITS-1:0]       cfg_data
);
    import trtr_pkg::*;

    localparam int OUT_BITS = ((2*PULSE_BITS+3+7)/8)*8;
    localparam int PAD_BITS = OUT_BITS - (2*PULSE_BITS+3);

    logic [COUNT_BITS-1:0] ramp1_ticks, ramp2_ticks;
    logic [PULSE_BITS-1:0] mc_servo_a, mc_servo_b;
    logic [PULSE_BITS-1:0] mid_servo_a, mid_servo_b;
    logic [PULSE_BITS-1:0] fw_servo_a, fw_servo_b;

    seq_state_t            state_reg, state_next;
    phase_t                phase_reg, phase_next;
    logic [COUNT_BITS-1:0] ramp1_count_reg, ramp1_count_next;
    logic [COUNT_BITS-1:0] ramp2_count_reg, ramp2_count_next;
    logic [PULSE_BITS-1:0] servo_a_hold_reg, servo_a_hold_next;
    logic [PULSE_BITS-1:0] servo_b_hold_reg, servo_b_hold_next;
    logic                  airframe_reg, airframe_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_BITS-1:0]   out_data_reg, out_data_next;

    logic                  in_accept;
    logic                  req_mc, req_fw;
    phase_t                phase_sel;
    logic                  lane_start;
    logic [PULSE_BITS-1:0] lane_a_from, lane_a_to, lane_b_from, lane_b_to;
    logic [COUNT_BITS-1:0] lane_k, lane_n;
    logic                  lane_a_done, lane_b_done;
    logic [PULSE_BITS-1:0] lane_a_y, lane_b_y;
    logic                  out_free;

    trtr_cfg #(
        .PULSE_BITS (PULSE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (cfg_valid && cfg_ready),
        .wr_index    (cfg_index),
        .wr_data     (cfg_data),
        .ramp1_ticks (ramp1_ticks),
        .ramp2_ticks (ramp2_ticks),
        .mc_servo_a  (mc_servo_a),
        .mc_servo_b  (mc_servo_b),
        .mid_servo_a (mid_servo_a),
        .mid_servo_b (mid_servo_b),
        .fw_servo_a  (fw_servo_a),
        .fw_servo_b  (fw_servo_b)
    );

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign req_mc        = s_axis_tdata[0];
    assign req_fw        = s_axis_tdata[1];
    assign out_free      = !out_valid_reg || m_axis_tready;

    // Apply the requests, fixed wing first
    assign phase_sel = req_fw ? PH_RAMP1 : (req_mc ? PH_MC : phase_reg);

    // Pick the lane end points and ratio for the active ramp
    assign lane_a_from = (phase_sel == PH_RAMP1) ? mc_servo_a  : mid_servo_a;
    assign lane_a_to   = (phase_sel == PH_RAMP1) ? mid_servo_a : fw_servo_a;
    assign lane_b_from = (phase_sel == PH_RAMP1) ? mc_servo_b  : mid_servo_b;
    assign lane_b_to   = (phase_sel == PH_RAMP1) ? mid_servo_b : fw_servo_b;
    assign lane_k      = (phase_sel == PH_RAMP1) ? (ramp1_count_reg + 1'b1)
                                                 : (ramp2_count_reg + 1'b1);
    assign lane_n      = (phase_sel == PH_RAMP1) ? ramp1_ticks : ramp2_ticks;
    assign lane_start  = in_accept
                      && (((phase_sel == PH_RAMP1) && (ramp1_count_reg < ramp1_ticks))
                       || ((phase_sel == PH_RAMP2) && (ramp2_count_reg < ramp2_ticks)));

    trtr_lerp #(
        .PULSE_BITS (PULSE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_lerp_a (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lane_start),
        .a     (lane_a_from),
        .b     (lane_a_to),
        .k     (lane_k),
        .n     (lane_n),
        .done  (lane_a_done),
        .y     (lane_a_y)
    );

    trtr_lerp #(
        .PULSE_BITS (PULSE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_lerp_b (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lane_start),
        .a     (lane_b_from),
        .b     (lane_b_to),
        .k     (lane_k),
        .n     (lane_n),
        .done  (lane_b_done),
        .y     (lane_b_y)
    );

    // Sequence the tick: update phase and counts, wait for lanes, emit
    always_comb
    begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        ramp1_count_next  = ramp1_count_reg;
        ramp2_count_next  = ramp2_count_reg;
        servo_a_hold_next = servo_a_hold_reg;
        servo_b_hold_next = servo_b_hold_reg;
        airframe_next     = airframe_reg;
        out_valid_next    = out_valid_reg;
        out_data_next     = out_data_reg;

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    phase_next = phase_sel;
                    state_next = S_EMIT;
                    case (phase_sel)
                        PH_RAMP1:
                        begin
                            if (ramp1_count_reg >= ramp1_ticks)
                            begin
                                phase_next = PH_RAMP2;
                            end
                            else
                            begin
                                ramp1_count_next = lane_k;
                                state_next       = S_CALC;
                            end
                        end
                        PH_RAMP2:
                        begin
                            if (ramp2_count_reg >= ramp2_ticks)
                            begin
                                phase_next       = PH_FW;
                                ramp1_count_next = '0;
                                ramp2_count_next = '0;
                            end
                            else
                            begin
                                ramp2_count_next = lane_k;
                                state_next       = S_CALC;
                            end
                        end
                        PH_FW:
                        begin
                            servo_a_hold_next = fw_servo_a;
                            servo_b_hold_next = fw_servo_b;
                            airframe_next     = AIR_FW;
                        end
                        default:
                        begin
                            servo_a_hold_next = mc_servo_a;
                            servo_b_hold_next = mc_servo_b;
                            airframe_next     = AIR_MC;
                        end
                    endcase
                end
            end
            S_CALC:
            begin
                if (lane_a_done && lane_b_done)
                begin
                    servo_a_hold_next = lane_a_y;
                    servo_b_hold_next = lane_b_y;
                    state_next        = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {{PAD_BITS{1'b0}}, phase_reg, airframe_reg,
                                      servo_b_hold_reg, servo_a_hold_reg};
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            phase_reg        <= PH_MC;
            ramp1_count_reg  <= '0;
            ramp2_count_reg  <= '0;
            servo_a_hold_reg <= '0;
            servo_b_hold_reg <= '0;
            airframe_reg     <= AIR_MC;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            ramp1_count_reg  <= ramp1_count_next;
            ramp2_count_reg  <= ramp2_count_next;
            servo_a_hold_reg <= servo_a_hold_next;
            servo_b_hold_reg <= servo_b_hold_next;
            airframe_reg     <= airframe_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Hold the result payload until the receiver takes it
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

### test/tilt_rotor_transition_ramp_test.sv
// Self-checking testbench for the tilt-rotor transition ramp.
`default_nettype none

module tilt_rotor_transition_ramp_test;
    import trtr_pkg::*;

    localparam int PULSE_W     = 12;
    localparam int COUNT_W     = 16;
    localparam int OUT_W       = ((2*PULSE_W+3+7)/8)*8;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TICK_TARGET = 1320;
    localparam int HOLD_OFF    = 400;

    // Request codes on tdata: bit 0 multicopter, bit 1 fixed wing
    localparam logic [1:0] REQ_NONE = 2'b00;
    localparam logic [1:0] REQ_MC   = 2'b01;
    localparam logic [1:0] REQ_FW   = 2'b10;
    localparam logic [1:0] REQ_BOTH = 2'b11;

    // Index with no register behind it
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 8'd9;

    localparam logic [CFG_INDEX_BITS-1:0] REG_ORDER [8] = '{
        REG_RAMP1_TICKS, REG_RAMP2_TICKS, REG_MC_SERVO_A, REG_MC_SERVO_B,
        REG_MID_SERVO_A, REG_MID_SERVO_B, REG_FW_SERVO_A, REG_FW_SERVO_B
    };

    localparam logic [1:0] OPENING_TICKS [14] = '{
        REQ_NONE, REQ_MC, REQ_FW, REQ_NONE, REQ_MC, REQ_FW, REQ_NONE,
        REQ_NONE, REQ_BOTH, REQ_NONE, REQ_NONE, REQ_NONE, REQ_FW, REQ_NONE
    };
    localparam logic [1:0] ZERO_LEN_TICKS [4] = '{REQ_NONE, REQ_NONE, REQ_NONE, REQ_FW};

    typedef struct {
        logic [PULSE_W-1:0] servo_a;
        logic [PULSE_W-1:0] servo_b;
        logic               fixed_wing;
        phase_t             phase;
    } servo_item_t;

    // Tracks the transition state and checks every returned servo item
    class transition_scoreboard;
        logic [COUNT_W-1:0] len1, len2;
        logic [PULSE_W-1:0] mc_a, mc_b, mid_a, mid_b, fw_a, fw_b;
        phase_t             phase;
        logic [COUNT_W-1:0] count1, count2;
        logic [PULSE_W-1:0] hold_a, hold_b;
        logic               airframe;
        servo_item_t        expected_items [$];
        int                 mismatches;
        int                 results_seen;
        int                 phase_hits [4];

        function new();
            len1 = COUNT_W'(RST_RAMP1_TICKS);
            len2 = COUNT_W'(RST_RAMP2_TICKS);
            mc_a = PULSE_W'(RST_MC_SERVO_A);
            mc_b = PULSE_W'(RST_MC_SERVO_B);
            mid_a = PULSE_W'(RST_MID_SERVO_A);
            mid_b = PULSE_W'(RST_MID_SERVO_B);
            fw_a = PULSE_W'(RST_FW_SERVO_A);
            fw_b = PULSE_W'(RST_FW_SERVO_B);
            phase = PH_MC;
            count1 = '0;
            count2 = '0;
            hold_a = '0;
            hold_b = '0;
            airframe = AIR_MC;
            mismatches = 0;
            results_seen = 0;
            foreach (phase_hits[i]) phase_hits[i] = 0;
        endfunction

        function int pending();
            return expected_items.size();
        endfunction

        task report(input string msg);
            mismatches++;
            if (mismatches <= 40)
                $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        function void write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                                input logic [CFG_DATA_BITS-1:0] data);
            case (index)
                REG_RAMP1_TICKS: len1 = data;
                REG_RAMP2_TICKS: len2 = data;
                REG_MC_SERVO_A:  mc_a = data[PULSE_W-1:0];
                REG_MC_SERVO_B:  mc_b = data[PULSE_W-1:0];
                REG_MID_SERVO_A: mid_a = data[PULSE_W-1:0];
                REG_MID_SERVO_B: mid_b = data[PULSE_W-1:0];
                REG_FW_SERVO_A:  fw_a = data[PULSE_W-1:0];
                REG_FW_SERVO_B:  fw_b = data[PULSE_W-1:0];
                default: ;
            endcase
        endfunction

        // floor(start + (stop - start) * k / n), exact
        function logic [PULSE_W-1:0] blend_pulse(input logic [PULSE_W-1:0] start,
                                                 input logic [PULSE_W-1:0] stop,
                                                 input logic [COUNT_W-1:0] k,
                                                 input logic [COUNT_W-1:0] n);
            longint num, den, q;
            num = (longint'(stop) - longint'(start)) * longint'(k);
            den = longint'(n);
            if (num >= 0)
                q = num / den;
            else
                q = -((-num + den - 1) / den);
            return PULSE_W'(longint'(start) + q);
        endfunction

        // Advance the sequencer by one accepted tick and queue its result
        function void note_tick(input logic req_mc, input logic req_fw);
            servo_item_t item;
            if (req_fw)
                phase = PH_RAMP1;
            else if (req_mc)
                phase = PH_MC;
            case (phase)
                PH_RAMP1:
                    if (count1 >= len1)
                        phase = PH_RAMP2;
                    else
                    begin
                        count1 = count1 + 1'b1;
                        hold_a = blend_pulse(mc_a, mid_a, count1, len1);
                        hold_b = blend_pulse(mc_b, mid_b, count1, len1);
                    end
                PH_RAMP2:
                    if (count2 >= len2)
                    begin
                        phase = PH_FW;
                        count1 = '0;
                        count2 = '0;
                    end
                    else
                    begin
                        count2 = count2 + 1'b1;
                        hold_a = blend_pulse(mid_a, fw_a, count2, len2);
                        hold_b = blend_pulse(mid_b, fw_b, count2, len2);
                    end
                PH_FW:
                begin
                    hold_a = fw_a;
                    hold_b = fw_b;
                    airframe = AIR_FW;
                end
                default:
                begin
                    hold_a = mc_a;
                    hold_b = mc_b;
                    airframe = AIR_MC;
                end
            endcase
            item.servo_a = hold_a;
            item.servo_b = hold_b;
            item.fixed_wing = airframe;
            item.phase = phase;
            expected_items.push_back(item);
        endfunction

        // Compare one returned item against the oldest expectation
        task check_result(input logic [OUT_W-1:0] tdata);
            servo_item_t exp_item;
            logic [PULSE_W-1:0] got_a, got_b;
            logic got_fw;
            phase_t got_phase;
            got_a = tdata[PULSE_W-1:0];
            got_b = tdata[2*PULSE_W-1:PULSE_W];
            got_fw = tdata[2*PULSE_W];
            got_phase = tdata[2*PULSE_W+2:2*PULSE_W+1];
            results_seen++;
            if (expected_items.size() == 0)
            begin
                report($sformatf("result 0x%0h with no tick waiting", tdata));
            end
            else
            begin
                exp_item = expected_items.pop_front();
                phase_hits[exp_item.phase]++;
                if (got_a !== exp_item.servo_a)
                    report($sformatf("result %0d servo_a_pulse %0d, expected %0d",
                                     results_seen, got_a, exp_item.servo_a));
                if (got_b !== exp_item.servo_b)
                    report($sformatf("result %0d servo_b_pulse %0d, expected %0d",
                                     results_seen, got_b, exp_item.servo_b));
                if (got_fw !== exp_item.fixed_wing)
                    report($sformatf("result %0d fixed_wing_mode %0b, expected %0b",
                                     results_seen, got_fw, exp_item.fixed_wing));
                if (got_phase !== exp_item.phase)
                    report($sformatf("result %0d tilt_phase %0d, expected %0d",
                                     results_seen, got_phase, exp_item.phase));
            end
        endtask
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [IN_DATA_BITS-1:0]   s_axis_tdata;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [OUT_W-1:0]          m_axis_tdata;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    transition_scoreboard sb = new();

    bit tx_idle_en;
    bit rx_idle_en;
    int rx_hold_left;
    int ticks_sent;
    int cfg_writes;
    int settings_used;
    int cycles;
    logic [CFG_DATA_BITS-1:0] setting [8];

    tilt_rotor_transition_ramp #(
        .PULSE_BITS(PULSE_W),
        .COUNT_BITS(COUNT_W)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Free-running clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Guard against a hung handshake
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tilt_rotor_transition_ramp regression: fail");
            $finish;
        end
    end

    // Check every item that leaves the block
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // Mostly short gaps, a few long ones
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function logic [CFG_DATA_BITS-1:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 16'd1;
        if (r < 15)
            return 16'hFFFF;
        if (r < 75)
            return CFG_DATA_BITS'($urandom_range(2, 8));
        return CFG_DATA_BITS'($urandom_range(9, 40));
    endfunction

    // Upper bits carry junk that the block must mask off
    function logic [CFG_DATA_BITS-1:0] pick_pulse_word();
        int r;
        logic [PULSE_W-1:0] pulse;
        r = $urandom_range(0, 99);
        if (r < 15)
            pulse = '0;
        else if (r < 30)
            pulse = '1;
        else
            pulse = PULSE_W'($urandom_range(0, 4095));
        return {4'($urandom_range(0, 15)), pulse};
    endfunction

    // Receiver: random stalls plus an occasional long hold-off
    initial
    begin
        int stall_left;
        bit ready_next;
        m_axis_tready = 1'b0;
        stall_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            ready_next = 1'b1;
            if (rx_hold_left > 0)
            begin
                ready_next = 1'b0;
                rx_hold_left--;
            end
            else if (stall_left > 0)
            begin
                ready_next = 1'b0;
                stall_left--;
            end
            else if (rx_idle_en && $urandom_range(0, 5) == 0)
            begin
                ready_next = 1'b0;
                stall_left = pick_gap() - 1;
            end
            m_axis_tready <= ready_next;
        end
    end

    // Offer one tick and hold it until the block takes it
    task send_tick(input logic [1:0] req);
        int gap;
        gap = 0;
        if (tx_idle_en && $urandom_range(0, 2) == 0)
            gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(IN_DATA_BITS-2){1'b0}}, req};
        do @(posedge clk); while (!s_axis_tready);
        sb.note_tick(req[0], req[1]);
        ticks_sent++;
    endtask

    // Drop valid and wait until every result has come back
    task settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                   input logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(index, data);
        cfg_writes++;
    endtask

    task end_cfg();
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Write all eight registers from the setting array
    task load_setting();
        for (int i = 0; i < 8; i++)
            write_reg(REG_ORDER[i], setting[i]);
        end_cfg();
        settings_used++;
    endtask

    // Fixed-wing request, then mostly quiet ticks with some noise
    task run_transition();
        int steps;
        int r;
        send_tick(REQ_FW);
        steps = int'(sb.len1) + int'(sb.len2) + 2 + $urandom_range(0, 4);
        if (steps > 90)
            steps = 90;
        for (int i = 0; i < steps; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
                send_tick(REQ_MC);
            else if (r < 8)
                send_tick(REQ_BOTH);
            else if (r < 11)
                send_tick(REQ_FW);
            else
                send_tick(REQ_NONE);
        end
        if ($urandom_range(0, 9) < 3)
        begin
            send_tick(REQ_MC);
            repeat ($urandom_range(1, 4)) send_tick(REQ_NONE);
        end
    endtask

    initial
    begin
        int phase_no;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rst_n = 1'b0;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        rx_hold_left = 0;
        ticks_sent = 0;
        cfg_writes = 0;
        settings_used = 0;

        // Reset
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Short ramps between opposite extremes of the pulse range
        setting = '{16'd3, 16'd2, 16'd0, 16'd4095, 16'd4095, 16'd0, 16'd0, 16'd4095};
        load_setting();
        // Mid-ramp multicopter request, both requests, restart from fixed wing
        foreach (OPENING_TICKS[i]) send_tick(OPENING_TICKS[i]);

        // Zero ramp lengths, the first one lowered below the running count
        settle();
        write_reg(REG_RAMP1_TICKS, 16'd0);
        write_reg(REG_RAMP2_TICKS, 16'd0);
        end_cfg();
        foreach (ZERO_LEN_TICKS[i]) send_tick(ZERO_LEN_TICKS[i]);

        // Unused index is ignored; oversized pulse value is masked
        settle();
        write_reg(REG_SPARE, 16'hFFFF);
        write_reg(REG_MC_SERVO_A, 16'hF00A);
        end_cfg();
        send_tick(REQ_MC);
        send_tick(REQ_NONE);

        // Random settings, each followed by a burst of transitions
        phase_no = 0;
        while (ticks_sent < TICK_TARGET)
        begin
            settle();
            setting[0] = pick_len();
            setting[1] = pick_len();
            for (int i = 2; i < 8; i++)
                setting[i] = pick_pulse_word();
            if (phase_no == 0)
            begin
                setting[0] = 16'd1;
                setting[1] = 16'd1;
            end
            else if (phase_no == 1)
            begin
                setting[0] = 16'hFFFF;
                setting[1] = 16'hFFFF;
            end
            load_setting();
            tx_idle_en = (phase_no % 3) != 0;
            rx_idle_en = (phase_no % 4) != 1;
            // Stall the receiver for a long stretch while ticks keep coming
            if (phase_no == 2)
            begin
                tx_idle_en = 1'b0;
                rx_hold_left = HOLD_OFF;
            end
            repeat ($urandom_range(1, 3)) run_transition();
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(3, 10)) send_tick(2'($urandom_range(0, 3)));
            phase_no++;
        end

        // Drain and let any stray result show up
        settle();
        repeat (80) @(posedge clk);
        while (sb.pending() != 0)
        begin
            sb.report("expected result never arrived");
            void'(sb.expected_items.pop_front());
        end

        $display("run covered %0d ticks over %0d register settings (%0d writes)",
                 ticks_sent, settings_used, cfg_writes);
        $display("results by phase: multicopter %0d, ramp one %0d, ramp two %0d, fixed wing %0d",
                 sb.phase_hits[PH_MC], sb.phase_hits[PH_RAMP1],
                 sb.phase_hits[PH_RAMP2], sb.phase_hits[PH_FW]);
        if (sb.mismatches == 0)
            $display("tilt_rotor_transition_ramp regression: pass");
        else
            $display("tilt_rotor_transition_ramp regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
